>>> src/vector_normalize_3d_defines.svh
// Assertion macros for the vector normalizer
`ifndef VECTOR_NORMALIZE_3D_DEFINES_SVH
`define VECTOR_NORMALIZE_3D_DEFINES_SVH
`ifndef SYNTH
`define VN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VN_ASSERT(lbl, clk, rst_n, prop, msg)
`define VN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/vn3d_pkg.sv
// Types and constants shared by the vector normalizer
package vn3d_pkg;
	localparam int CompW = 32;
	localparam int SumW  = 64;
	localparam int RootW = 32;
	localparam int FracShift = 30;
	localparam int DivW  = CompW + FracShift;

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] vec_w;
	} vec_in_t;

	typedef struct packed {
		logic signed [31:0] unit_x;
		logic signed [31:0] unit_y;
		logic signed [31:0] unit_z;
		logic signed [31:0] out_w;
		logic [31:0]        length;
		logic               zero_vector;
	} vec_out_t;
endpackage

>>> src/vector_normalize_3d.sv
// Vector normalizer top level: square stage, square root cell chain, divider cell chain
//
//   channel | signals                  | handshake
//   input   | start, busy, vec_in      | taken when start && !busy
//   output  | done, vec_out            | one-cycle strobe, cannot stall
//
// Fully pipelined: one vector per cycle through the magnitude, square and sum
// stages, one root cell per result bit, one divide cell per quotient bit and the
// output register.
// busy is always low. Reset clears only the valid chain; payload flows unreset.
`include "vector_normalize_3d_defines.svh"
module vector_normalize_3d import vn3d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  vec_in_t  vec_in,
	output logic     done,
	output vec_out_t vec_out
);
	localparam int NSq  = RootW;
	localparam int NDiv = DivW;

	assign busy = 1'b0;

	// stage 1: magnitudes
	logic             vld_s1;
	logic [CompW-1:0] mx_s1, my_s1, mz_s1, w_s1;
	logic [2:0]       neg_s1;
	// stage 2: squares
	logic             vld_s2;
	logic [SumW-1:0]  px_s2, py_s2, pz_s2;
	logic [CompW-1:0] mx_s2, my_s2, mz_s2, w_s2;
	logic [2:0]       neg_s2;
	// stage 3: sum
	logic             vld_s3;
	logic [SumW-1:0]  sum_s3;
	logic [CompW-1:0] mx_s3, my_s3, mz_s3, w_s3;
	logic [2:0]       neg_s3;

	function automatic logic [CompW-1:0] mag(input logic [CompW-1:0] v);
		mag = v[CompW-1] ? (~v + 1'b1) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1  <= mag(vec_in.vec_x);
		my_s1  <= mag(vec_in.vec_y);
		mz_s1  <= mag(vec_in.vec_z);
		neg_s1 <= {vec_in.vec_x[CompW-1], vec_in.vec_y[CompW-1], vec_in.vec_z[CompW-1]};
		w_s1   <= vec_in.vec_w;
		px_s2  <= SumW'(mx_s1) * SumW'(mx_s1);
		py_s2  <= SumW'(my_s1) * SumW'(my_s1);
		pz_s2  <= SumW'(mz_s1) * SumW'(mz_s1);
		mx_s2  <= mx_s1;
		my_s2  <= my_s1;
		mz_s2  <= mz_s1;
		neg_s2 <= neg_s1;
		w_s2   <= w_s1;
		sum_s3 <= px_s2 + py_s2 + pz_s2;
		mx_s3  <= mx_s2;
		my_s3  <= my_s2;
		mz_s3  <= mz_s2;
		neg_s3 <= neg_s2;
		w_s3   <= w_s2;
	end

	// square root chain
	logic [SumW-1:0]  srem [NSq+1];
	logic [RootW-1:0] sroot [NSq+1];
	logic [SumW-1:0]  srad [NSq+1];
	logic [CompW-1:0] smx [NSq+1];
	logic [CompW-1:0] smy [NSq+1];
	logic [CompW-1:0] smz [NSq+1];
	logic [2:0]       sneg [NSq+1];
	logic [CompW-1:0] sw [NSq+1];

	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign srad[0]  = sum_s3;
	assign smx[0]   = mx_s3;
	assign smy[0]   = my_s3;
	assign smz[0]   = mz_s3;
	assign sneg[0]  = neg_s3;
	assign sw[0]    = w_s3;

	for (genvar i = 0; i < NSq; i++) begin : g_sqrt
		vn3d_sqrt_cell u_cell (
			.clk(clk),
			.rem_in(srem[i]), .root_in(sroot[i]), .rad_in(srad[i]),
			.mag_x_in(smx[i]), .mag_y_in(smy[i]), .mag_z_in(smz[i]),
			.neg_in(sneg[i]), .w_in(sw[i]),
			.rem_out(srem[i+1]), .root_out(sroot[i+1]), .rad_out(srad[i+1]),
			.mag_x_out(smx[i+1]), .mag_y_out(smy[i+1]), .mag_z_out(smz[i+1]),
			.neg_out(sneg[i+1]), .w_out(sw[i+1])
		);
	end

	// valid chain kept in reset flops, one bit per root cell
	logic [NSq-1:0] sqv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sqv_q <= '0;
		else sqv_q <= {sqv_q[NSq-2:0], vld_s3};
	end

	// divide chain
	logic [RootW-1:0] dden [NDiv+1];
	logic [DivW-1:0]  dnx [NDiv+1];
	logic [DivW-1:0]  dny [NDiv+1];
	logic [DivW-1:0]  dnz [NDiv+1];
	logic [RootW:0]   drx [NDiv+1];
	logic [RootW:0]   dry [NDiv+1];
	logic [RootW:0]   drz [NDiv+1];
	logic [2:0]       dneg [NDiv+1];
	logic [CompW-1:0] dw [NDiv+1];

	assign dden[0] = sroot[NSq];
	assign dnx[0]  = {smx[NSq], {FracShift{1'b0}}};
	assign dny[0]  = {smy[NSq], {FracShift{1'b0}}};
	assign dnz[0]  = {smz[NSq], {FracShift{1'b0}}};
	assign drx[0]  = '0;
	assign dry[0]  = '0;
	assign drz[0]  = '0;
	assign dneg[0] = sneg[NSq];
	assign dw[0]   = sw[NSq];

	for (genvar i = 0; i < NDiv; i++) begin : g_div
		vn3d_div_cell u_cell (
			.clk(clk), .den_in(dden[i]),
			.num_x_in(dnx[i]), .num_y_in(dny[i]), .num_z_in(dnz[i]),
			.rem_x_in(drx[i]), .rem_y_in(dry[i]), .rem_z_in(drz[i]),
			.neg_in(dneg[i]), .w_in(dw[i]),
			.den_out(dden[i+1]),
			.num_x_out(dnx[i+1]), .num_y_out(dny[i+1]), .num_z_out(dnz[i+1]),
			.rem_x_out(drx[i+1]), .rem_y_out(dry[i+1]), .rem_z_out(drz[i+1]),
			.neg_out(dneg[i+1]), .w_out(dw[i+1])
		);
	end

	logic [NDiv-1:0] dvv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dvv_q <= '0;
		else dvv_q <= {dvv_q[NDiv-2:0], sqv_q[NSq-1]};
	end

	// output stage
	logic     done_q;
	vec_out_t out_q;
	logic     zero;
	logic [CompW-1:0] qx, qy, qz;

	always_comb begin
		zero = (dden[NDiv] == '0);
		qx = dnx[NDiv][CompW-1:0];
		qy = dny[NDiv][CompW-1:0];
		qz = dnz[NDiv][CompW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= dvv_q[NDiv-1];
	end

	always_ff @(posedge clk) begin
		out_q.unit_x      <= zero ? '0 : (dneg[NDiv][2] ? (~qx + 1'b1) : qx);
		out_q.unit_y      <= zero ? '0 : (dneg[NDiv][1] ? (~qy + 1'b1) : qy);
		out_q.unit_z      <= zero ? '0 : (dneg[NDiv][0] ? (~qz + 1'b1) : qz);
		out_q.out_w       <= dw[NDiv];
		out_q.length      <= dden[NDiv];
		out_q.zero_vector <= zero;
	end

	assign done    = done_q;
	assign vec_out = out_q;

	`VN_ASSERT(a_never_busy, clk, arst_n, !busy, "busy raised")
	`VN_ASSERT_NEXT(a_fill, clk, arst_n, start, vld_s1, "accepted item not tracked")
	`VN_ASSERT_NEXT(a_done, clk, arst_n, dvv_q[NDiv-1], done, "result strobe lost")
	`VN_ASSERT(a_zero_len, clk, arst_n,
		done |-> (vec_out.zero_vector == (vec_out.length == '0)), "zero flag mismatch")
endmodule

>>> src/vn3d_sqrt_cell.sv
// One restoring square root step: consumes two bits of the radicand per cell
module vn3d_sqrt_cell import vn3d_pkg::*; (
	input  logic              clk,
	input  logic [SumW-1:0]   rem_in,
	input  logic [RootW-1:0]  root_in,
	input  logic [SumW-1:0]   rad_in,
	input  logic [CompW-1:0]  mag_x_in,
	input  logic [CompW-1:0]  mag_y_in,
	input  logic [CompW-1:0]  mag_z_in,
	input  logic [2:0]        neg_in,
	input  logic [CompW-1:0]  w_in,
	output logic [SumW-1:0]   rem_out,
	output logic [RootW-1:0]  root_out,
	output logic [SumW-1:0]   rad_out,
	output logic [CompW-1:0]  mag_x_out,
	output logic [CompW-1:0]  mag_y_out,
	output logic [CompW-1:0]  mag_z_out,
	output logic [2:0]        neg_out,
	output logic [CompW-1:0]  w_out
);
	logic [SumW+1:0] rem_sh;
	logic [SumW+1:0] trial;
	logic [SumW+1:0] diff;

	always_comb begin
		rem_sh = {rem_in, rad_in[SumW-1 -: 2]};
		trial  = {{(SumW-RootW){1'b0}}, root_in, 2'b01};
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk) begin
		rad_out   <= rad_in << 2;
		mag_x_out <= mag_x_in;
		mag_y_out <= mag_y_in;
		mag_z_out <= mag_z_in;
		neg_out   <= neg_in;
		w_out     <= w_in;
		if (!diff[SumW+1]) begin
			rem_out  <= diff[SumW-1:0];
			root_out <= {root_in[RootW-2:0], 1'b1};
		end else begin
			rem_out  <= rem_sh[SumW-1:0];
			root_out <= {root_in[RootW-2:0], 1'b0};
		end
	end
endmodule

>>> src/vn3d_div_cell.sv
// One restoring division step for the three components against a shared divisor
module vn3d_div_cell import vn3d_pkg::*; (
	input  logic              clk,
	input  logic [RootW-1:0]  den_in,
	input  logic [DivW-1:0]   num_x_in,
	input  logic [DivW-1:0]   num_y_in,
	input  logic [DivW-1:0]   num_z_in,
	input  logic [RootW:0]    rem_x_in,
	input  logic [RootW:0]    rem_y_in,
	input  logic [RootW:0]    rem_z_in,
	input  logic [2:0]        neg_in,
	input  logic [CompW-1:0]  w_in,
	output logic [RootW-1:0]  den_out,
	output logic [DivW-1:0]   num_x_out,
	output logic [DivW-1:0]   num_y_out,
	output logic [DivW-1:0]   num_z_out,
	output logic [RootW:0]    rem_x_out,
	output logic [RootW:0]    rem_y_out,
	output logic [RootW:0]    rem_z_out,
	output logic [2:0]        neg_out,
	output logic [CompW-1:0]  w_out
);
	function automatic logic [RootW:0] dstep(input logic [RootW:0] r, input logic b,
		input logic [RootW-1:0] d, output logic q);
		logic [RootW+1:0] sh;
		logic [RootW+1:0] df;
		begin
			sh = {r, b};
			df = sh - {2'b00, d};
			q  = !df[RootW+1];
			dstep = q ? df[RootW:0] : sh[RootW:0];
		end
	endfunction

	logic qx, qy, qz;
	logic [RootW:0] rx, ry, rz;

	always_comb begin
		rx = dstep(rem_x_in, num_x_in[DivW-1], den_in, qx);
		ry = dstep(rem_y_in, num_y_in[DivW-1], den_in, qy);
		rz = dstep(rem_z_in, num_z_in[DivW-1], den_in, qz);
	end

	always_ff @(posedge clk) begin
		den_out   <= den_in;
		neg_out   <= neg_in;
		w_out     <= w_in;
		rem_x_out <= rx;
		rem_y_out <= ry;
		rem_z_out <= rz;
		num_x_out <= {num_x_in[DivW-2:0], qx};
		num_y_out <= {num_y_in[DivW-2:0], qy};
		num_z_out <= {num_z_in[DivW-2:0], qz};
	end
endmodule
